// ----- hdl/fpr_pkg.sv -----
// Shared types and constants for the FLAC predictor restoration core.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

    localparam int MAX_ORDER = 32;
    localparam int SMP_W     = 32;
    localparam int COEF_W    = 15;
    localparam int OPC_W     = 2;
    localparam int CIDX_W    = 5;
    localparam int ORD_W     = 6;
    localparam int SHIFT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 6;
    localparam int CNT_W     = $clog2(MAX_ORDER);
    localparam int PROD_W    = SMP_W + COEF_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_ORDER);

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_WARM  = 2'd1,
        OP_RESID = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND  = 2'd0,
        CFG_ORDER = 2'd1,
        CFG_SHIFT = 2'd2,
        CFG_SPARE = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_DRAIN,
        S_PRED,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic push;
        logic rotate;
    } t_cell_ctrl;

    typedef struct packed {
        logic clear;
        logic tap;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// ----- hdl/fpr_in_if.sv -----
// Input channel of the predictor restoration core: valid/ready plus item fields.
// Depends on fpr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fpr_in_if;
    logic                                valid;
    logic                                ready;
    logic        [fpr_pkg::OPC_W-1:0]    opcode;
    logic signed [fpr_pkg::SMP_W-1:0]    value;
    logic        [fpr_pkg::CIDX_W-1:0]   coeff_index;
    logic                                end_of_block;

    modport source (output valid, opcode, value, coeff_index, end_of_block, input ready);
    modport sink   (input valid, opcode, value, coeff_index, end_of_block, output ready);
endinterface

`default_nettype wire

// ----- hdl/fpr_out_if.sv -----
// Output channel of the predictor restoration core: valid/ready plus sample fields.
// Depends on fpr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fpr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [fpr_pkg::SMP_W-1:0] sample;
    logic                             last;

    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/fpr_cell.sv -----
// One cell of the history chain: a past sample and its LPC coefficient.
// Shifts toward higher cells on push, rotates toward cell 0 during LPC. Uses fpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpr_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  fpr_pkg::t_cell_ctrl          i_ctrl,
    input  wire                          i_coef_we,
    input  wire [fpr_pkg::COEF_W-1:0]    i_coef_data,
    input  wire [fpr_pkg::SMP_W-1:0]     i_push_smp,
    input  wire [fpr_pkg::SMP_W-1:0]     i_rot_smp,
    input  wire [fpr_pkg::COEF_W-1:0]    i_rot_coef,
    output logic [fpr_pkg::SMP_W-1:0]    o_smp,
    output logic [fpr_pkg::COEF_W-1:0]   o_coef
);

    logic [fpr_pkg::SMP_W-1:0]  r_smp, n_smp;
    logic [fpr_pkg::COEF_W-1:0] r_coef, n_coef;

    always_comb begin
        priority if (i_ctrl.push) begin
            n_smp = i_push_smp;
        end else if (i_ctrl.rotate) begin
            n_smp = i_rot_smp;
        end else begin
            n_smp = r_smp;
        end
        priority if (i_coef_we) begin
            n_coef = i_coef_data;
        end else if (i_ctrl.rotate) begin
            n_coef = i_rot_coef;
        end else begin
            n_coef = r_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
        end else begin
            r_smp <= n_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_smp  = r_smp;
    assign o_coef = r_coef;

endmodule

`default_nettype wire

// ----- hdl/fpr_mac.sv -----
// Multiply-accumulate unit fed by cell 0 of the chain; forms the shifted LPC prediction.
// Registered product, then accumulate. Uses fpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpr_mac (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  fpr_pkg::t_mac_ctrl           i_ctrl,
    input  wire [fpr_pkg::COEF_W-1:0]    i_coef,
    input  wire [fpr_pkg::SMP_W-1:0]     i_smp,
    input  wire [fpr_pkg::SHIFT_W-1:0]   i_shift,
    output logic [fpr_pkg::SMP_W-1:0]    o_pred
);

    localparam int PROD_W = fpr_pkg::PROD_W;
    localparam int ACC_W  = fpr_pkg::ACC_W;

    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic                     r_prod_vld, n_prod_vld;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [ACC_W-1:0]  w_shifted;

    always_comb begin
        n_prod     = $signed(i_coef) * $signed(i_smp);
        n_prod_vld = i_ctrl.tap && !i_ctrl.clear;
        n_acc      = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (r_prod_vld) begin
            n_acc = r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= n_prod_vld;
            r_acc      <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign w_shifted = r_acc >>> i_shift;
    assign o_pred    = w_shifted[fpr_pkg::SMP_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/flac_predictor_restore_core.sv -----
// Top level of the FLAC fixed/LPC predictor restoration core.
// Depends on fpr_pkg, fpr_in_if, fpr_out_if, fpr_cell and fpr_mac.
//
// Usage:
//   i_smp carries items: load coefficient, warm-up sample or residual.
//   o_smp carries one reconstructed (or echoed warm-up) sample per sample item,
//   with last copying end_of_block. Load items and opcode three give no beat.
//   i_cfg_we/i_cfg_idx/i_cfg_data write kind, order and shift; the user must
//   write them only while idle, which the block itself does not enforce.
// Sequence:
//   Load and ignored items are taken in IDLE. A warm-up goes IDLE, PUSH; a
//   fixed-mode residual IDLE, PRED, PUSH. An LPC residual rotates all MAX_ORDER
//   cells of the history chain past the single multiplier at cell 0 in ROT,
//   then passes DRAIN, PRED and PUSH before the core takes the next item.
// Reset clears the history, kind, order and shift to zero and the output beat;
//   coefficients hold no defined value until loaded.
// A stalled receiver holds the output beat; one further item is accepted and
//   worked on, and its result waits in the final stage until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module flac_predictor_restore_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    fpr_in_if.sink                             i_smp,
    fpr_out_if.source                          o_smp,
    input  wire                                i_cfg_we,
    input  wire [fpr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [fpr_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int N     = fpr_pkg::MAX_ORDER;
    localparam int SMP_W = fpr_pkg::SMP_W;

    fpr_pkg::t_state                 r_state, n_state;
    logic                            r_kind;
    logic [fpr_pkg::ORD_W-1:0]       r_order;
    logic [fpr_pkg::SHIFT_W-1:0]     r_shift;
    logic [fpr_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [SMP_W-1:0]                r_value, n_value;
    logic                            r_last, n_last;
    logic [SMP_W-1:0]                r_pred, n_pred;
    logic                            r_out_valid, n_out_valid;
    logic [SMP_W-1:0]                r_out_sample, n_out_sample;
    logic                            r_out_last, n_out_last;

    logic [SMP_W-1:0]                w_smp      [N];
    logic [fpr_pkg::COEF_W-1:0]      w_coef     [N];
    logic [SMP_W-1:0]                w_push_in  [N];
    logic                            w_coef_we  [N];
    logic                            w_coef_wr;
    logic                            w_accept;
    logic [SMP_W-1:0]                w_new;
    logic [SMP_W-1:0]                w_fixed;
    logic [SMP_W-1:0]                w_mac_pred;
    logic [fpr_pkg::ORD_W-1:0]       w_eff_order;
    fpr_pkg::t_cell_ctrl             w_cell_ctrl;
    fpr_pkg::t_mac_ctrl              w_mac_ctrl;

    assign i_smp.ready = (r_state == fpr_pkg::S_IDLE);
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign w_new       = r_pred + r_value;
    assign w_eff_order = (r_order > fpr_pkg::ORD_W'(N)) ? fpr_pkg::ORD_W'(N) : r_order;

    always_comb begin
        unique case (r_order)
            6'd1:    w_fixed = w_smp[0];
            6'd2:    w_fixed = (w_smp[0] * 32'd2) - w_smp[1];
            6'd3:    w_fixed = (w_smp[0] * 32'd3) - (w_smp[1] * 32'd3) + w_smp[2];
            6'd4:    w_fixed = (w_smp[0] * 32'd4) - (w_smp[1] * 32'd6)
                               + (w_smp[2] * 32'd4) - w_smp[3];
            default: w_fixed = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= 1'b0;
            r_order <= '0;
            r_shift <= '0;
        end else if (i_cfg_we) begin
            unique case (fpr_pkg::t_cfg_idx'(i_cfg_idx))
                fpr_pkg::CFG_KIND:  r_kind  <= i_cfg_data[0];
                fpr_pkg::CFG_ORDER: r_order <= i_cfg_data[fpr_pkg::ORD_W-1:0];
                fpr_pkg::CFG_SHIFT: r_shift <= i_cfg_data[fpr_pkg::SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_value      = r_value;
        n_last       = r_last;
        n_pred       = r_pred;
        n_out_valid  = r_out_valid && !o_smp.ready;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        w_coef_wr    = 1'b0;
        w_cell_ctrl  = '0;
        w_mac_ctrl   = '0;
        unique case (r_state)
            fpr_pkg::S_IDLE: begin
                w_mac_ctrl.clear = 1'b1;
                n_cnt            = '0;
                if (w_accept) begin
                    n_value = i_smp.value;
                    n_last  = i_smp.end_of_block;
                    unique case (fpr_pkg::t_opcode'(i_smp.opcode))
                        fpr_pkg::OP_LOAD: begin
                            w_coef_wr = (32'(i_smp.coeff_index) < N);
                        end
                        fpr_pkg::OP_WARM: begin
                            n_pred  = '0;
                            n_state = fpr_pkg::S_PUSH;
                        end
                        fpr_pkg::OP_RESID: begin
                            n_state = r_kind ? fpr_pkg::S_ROT : fpr_pkg::S_PRED;
                        end
                        fpr_pkg::OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fpr_pkg::S_ROT: begin
                w_cell_ctrl.rotate = 1'b1;
                w_mac_ctrl.tap     = (fpr_pkg::ORD_W'(r_cnt) < w_eff_order);
                n_cnt              = r_cnt + 1'b1;
                if (r_cnt == fpr_pkg::CNT_W'(N - 1)) begin
                    n_state = fpr_pkg::S_DRAIN;
                end
            end
            fpr_pkg::S_DRAIN: begin
                n_state = fpr_pkg::S_PRED;
            end
            fpr_pkg::S_PRED: begin
                n_pred  = r_kind ? w_mac_pred : w_fixed;
                n_state = fpr_pkg::S_PUSH;
            end
            fpr_pkg::S_PUSH: begin
                if (!r_out_valid || o_smp.ready) begin
                    w_cell_ctrl.push = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out_sample     = w_new;
                    n_out_last       = r_last;
                    n_state          = fpr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpr_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_last       <= n_last;
        r_pred       <= n_pred;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        localparam int NXT = (g + 1) % N;
        localparam int PRV = (g == 0) ? 0 : g - 1;

        assign w_push_in[g] = (g == 0) ? w_new : w_smp[PRV];
        assign w_coef_we[g] = w_coef_wr && (i_smp.coeff_index == fpr_pkg::CIDX_W'(g));

        fpr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_cell_ctrl),
            .i_coef_we   (w_coef_we[g]),
            .i_coef_data (i_smp.value[fpr_pkg::COEF_W-1:0]),
            .i_push_smp  (w_push_in[g]),
            .i_rot_smp   (w_smp[NXT]),
            .i_rot_coef  (w_coef[NXT]),
            .o_smp       (w_smp[g]),
            .o_coef      (w_coef[g])
        );
    end

    fpr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_coef  (w_coef[0]),
        .i_smp   (w_smp[0]),
        .i_shift (r_shift),
        .o_pred  (w_mac_pred)
    );

    assign o_smp.valid  = r_out_valid;
    assign o_smp.sample = r_out_sample;
    assign o_smp.last   = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/fpr_checker.sv -----
// Port-level checks for flac_predictor_restore_core, attached by bind.
// Depends on fpr_pkg for widths and opcodes.
`timescale 1ns / 1ps
`default_nettype none

module fpr_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              i_in_ready,
    input wire [fpr_pkg::OPC_W-1:0]         i_in_opcode,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire [fpr_pkg::SMP_W-1:0]         i_out_sample,
    input wire                              i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample) && $stable(i_out_last))
        else $error("stalled output beat changed");

    a_warm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_opcode == fpr_pkg::OP_WARM) |=> !i_in_ready)
        else $error("input taken while a warm-up sample is in flight");

    a_no_early_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("output beat appeared too soon after an input beat");

endmodule

bind flac_predictor_restore_core fpr_checker u_fpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_in_opcode  (i_smp.opcode),
    .i_out_valid  (o_smp.valid),
    .i_out_ready  (o_smp.ready),
    .i_out_sample (o_smp.sample),
    .i_out_last   (o_smp.last)
);

`default_nettype wire

// ----- bench/tb_flac_predictor_restore_core.sv -----
// Self-checking bench for flac_predictor_restore_core: directed table, then random subframes
// scored against a fixed/LPC sample predictor. Needs fpr_pkg, fpr_in_if, fpr_out_if and the RTL.
`timescale 1ns / 1ps

module tb_flac_predictor_restore_core;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = fpr_pkg::MAX_ORDER + 8;
    localparam int HOLD_AT_BEAT   = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 820;
    localparam int DIR_ROWS       = 37;

    typedef struct packed {
        fpr_pkg::t_opcode                 op;
        logic [fpr_pkg::SMP_W-1:0]        value;
        logic [fpr_pkg::CIDX_W-1:0]       cidx;
        logic                             eob;
    } t_smp_item;

    typedef struct packed {
        logic [fpr_pkg::SMP_W-1:0]        sample;
        logic                             last;
    } t_smp_beat;

    typedef enum logic {
        ROW_REG  = 1'b0,
        ROW_ITEM = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        fpr_pkg::t_cfg_idx                reg_idx;
        logic [fpr_pkg::CFG_W-1:0]        reg_data;
        t_smp_item                        item;
        logic                             fixed_want;
        logic [fpr_pkg::SMP_W-1:0]        want;
    } t_dir_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [fpr_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [fpr_pkg::CFG_W-1:0]         i_cfg_data;

    fpr_in_if  smp_in();
    fpr_out_if smp_out();

    flac_predictor_restore_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_in),
        .o_smp      (smp_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [fpr_pkg::SMP_W-1:0]         past_samples [fpr_pkg::MAX_ORDER];
    logic signed [fpr_pkg::COEF_W-1:0] lpc_coefs [fpr_pkg::MAX_ORDER];
    logic                              cfg_lpc;
    logic [fpr_pkg::ORD_W-1:0]         cfg_order;
    logic [fpr_pkg::SHIFT_W-1:0]       cfg_shift;

    t_smp_beat  pending_samples [$];
    t_smp_beat  oldest;
    int         items_taken = 0;
    int         beats_seen = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    logic       calm = 1'b0;
    logic       held = 1'b0;
    logic       reg_busy = 1'b0;
    t_dir_row   dir_table [DIR_ROWS];

    function automatic logic restore_sample(input t_smp_item it, output t_smp_beat beat);
        logic [fpr_pkg::SMP_W-1:0] a, b, c, d, pred, s;
        logic signed [63:0]        acc, tap_c, tap_s;
        int                        taps;
        beat = '0;
        pred = '0;
        if (it.op == fpr_pkg::OP_LOAD) begin
            lpc_coefs[it.cidx] = it.value[fpr_pkg::COEF_W-1:0];
            return 1'b0;
        end
        if (it.op == fpr_pkg::OP_NONE) return 1'b0;
        if (it.op == fpr_pkg::OP_RESID) begin
            if (cfg_lpc) begin
                taps = (cfg_order > fpr_pkg::MAX_ORDER) ? fpr_pkg::MAX_ORDER : int'(cfg_order);
                acc = '0;
                for (int j = 0; j < taps; j++) begin
                    tap_c = lpc_coefs[j];
                    tap_s = $signed(past_samples[j]);
                    acc = acc + tap_c * tap_s;
                end
                acc = acc >>> cfg_shift;
                pred = acc[fpr_pkg::SMP_W-1:0];
            end else begin
                a = past_samples[0];
                b = past_samples[1];
                c = past_samples[2];
                d = past_samples[3];
                case (cfg_order)
                    6'd1: pred = a;
                    6'd2: pred = 32'd2 * a - b;
                    6'd3: pred = 32'd3 * a - 32'd3 * b + c;
                    6'd4: pred = 32'd4 * a - 32'd6 * b + 32'd4 * c - d;
                    default: pred = '0;
                endcase
            end
            s = pred + it.value;
        end else begin
            s = it.value;
        end
        for (int j = fpr_pkg::MAX_ORDER - 1; j > 0; j--) past_samples[j] = past_samples[j-1];
        past_samples[0] = s;
        beat.sample = s;
        beat.last = it.eob;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [fpr_pkg::SMP_W-1:0] sample_value();
        logic [fpr_pkg::SMP_W-1:0] v;
        int                        r;
        r = $urandom_range(0, 9);
        v = $urandom;
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = '0;
                default: v = '1;
            endcase
        end else if (r > 3) begin
            v = $signed(v) >>> $urandom_range(12, 28);
        end
        return v;
    endfunction

    function automatic t_dir_row reg_row(input fpr_pkg::t_cfg_idx idx,
                                         input logic [fpr_pkg::CFG_W-1:0] data);
        t_dir_row row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic t_dir_row item_row(input fpr_pkg::t_opcode op,
                                          input logic [fpr_pkg::SMP_W-1:0] value,
                                          input logic [fpr_pkg::CIDX_W-1:0] cidx,
                                          input logic eob, input logic fixed_want);
        t_dir_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item.op = op;
        row.item.value = value;
        row.item.cidx = cidx;
        row.item.eob = eob;
        row.fixed_want = fixed_want;
        row.want = value;
        return row;
    endfunction

    task automatic settle();
        smp_in.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input fpr_pkg::t_cfg_idx idx,
                             input logic [fpr_pkg::CFG_W-1:0] data);
        if (!reg_busy) begin
            settle();
            reg_busy = 1'b1;
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            fpr_pkg::CFG_KIND:  cfg_lpc = data[0];
            fpr_pkg::CFG_ORDER: cfg_order = data[fpr_pkg::ORD_W-1:0];
            fpr_pkg::CFG_SHIFT: cfg_shift = data[fpr_pkg::SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drive_item(input t_smp_item it, input logic fixed_want,
                              input logic [fpr_pkg::SMP_W-1:0] want);
        int        gap;
        t_smp_beat beat;
        if (reg_busy) begin
            i_cfg_we <= 1'b0;
            reg_busy = 1'b0;
        end
        gap = pick_gap();
        if (gap > 0) begin
            smp_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_in.valid        <= 1'b1;
        smp_in.opcode       <= it.op;
        smp_in.value        <= it.value;
        smp_in.coeff_index  <= it.cidx;
        smp_in.end_of_block <= it.eob;
        do @(posedge i_clk); while (smp_in.ready !== 1'b1);
        if (it.op != fpr_pkg::OP_NONE) items_taken++;
        if (restore_sample(it, beat)) begin
            if (fixed_want) beat.sample = want;
            pending_samples.push_back(beat);
        end
    endtask

    task automatic send(input fpr_pkg::t_opcode op, input logic [fpr_pkg::SMP_W-1:0] value,
                        input logic [fpr_pkg::CIDX_W-1:0] cidx, input logic eob);
        t_smp_item it;
        it.op = op;
        it.value = value;
        it.cidx = cidx;
        it.eob = eob;
        drive_item(it, 1'b0, '0);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 2))
                0: send(fpr_pkg::OP_NONE, $urandom, 5'($urandom), 1'($urandom));
                1: send(fpr_pkg::OP_LOAD, $urandom, 5'($urandom), 1'($urandom));
                default: send(fpr_pkg::OP_WARM, sample_value(), 5'($urandom), 1'b1);
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && smp_out.valid === 1'b1 && smp_out.ready === 1'b1) begin
            beats_seen++;
            if (pending_samples.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat: sample %h last %b", $time,
                         smp_out.sample, smp_out.last);
            end else begin
                oldest = pending_samples.pop_front();
                if (smp_out.sample !== oldest.sample) begin
                    mismatches++;
                    $display("%0t: sample mismatch: expected %h actual %h", $time,
                             oldest.sample, smp_out.sample);
                end
                if (smp_out.last !== oldest.last) begin
                    mismatches++;
                    $display("%0t: last mismatch: expected %b actual %b", $time,
                             oldest.last, smp_out.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((smp_in.valid === 1'b1 && smp_in.ready === 1'b1) ||
            (smp_out.valid === 1'b1 && smp_out.ready === 1'b1) || i_cfg_we === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : sink_side
        int stall;
        smp_out.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && beats_seen >= HOLD_AT_BEAT && smp_in.valid === 1'b1) begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                smp_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            smp_out.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic                        use_lpc;
        logic [fpr_pkg::ORD_W-1:0]   ord;
        logic [fpr_pkg::SHIFT_W-1:0] shf;
        int                          r, taps, nsub, nwarm, nres;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= '0;
        i_cfg_data          <= '0;
        smp_in.valid        <= 1'b0;
        smp_in.opcode       <= fpr_pkg::OP_LOAD;
        smp_in.value        <= '0;
        smp_in.coeff_index  <= '0;
        smp_in.end_of_block <= 1'b0;
        cfg_lpc   = 1'b0;
        cfg_order = '0;
        cfg_shift = '0;
        for (int j = 0; j < fpr_pkg::MAX_ORDER; j++) begin
            past_samples[j] = '0;
            lpc_coefs[j] = '0;
        end

        dir_table = '{
            item_row(fpr_pkg::OP_RESID, 32'h7FFF_FFFF, 5'd0, 1'b0, 1'b1),
            item_row(fpr_pkg::OP_RESID, 32'h8000_0000, 5'd0, 1'b1, 1'b1),
            item_row(fpr_pkg::OP_WARM,  32'hFFFF_FFFF, 5'd0, 1'b0, 1'b1),
            item_row(fpr_pkg::OP_NONE,  32'hDEAD_BEEF, 5'd31, 1'b1, 1'b0),
            reg_row(fpr_pkg::CFG_ORDER, 6'd4),
            reg_row(fpr_pkg::CFG_SPARE, 6'h3F),
            item_row(fpr_pkg::OP_WARM,  32'h7FFF_FFFF, 5'd0, 1'b0, 1'b1),
            item_row(fpr_pkg::OP_WARM,  32'h8000_0000, 5'd0, 1'b0, 1'b1),
            item_row(fpr_pkg::OP_WARM,  32'h7FFF_FFFF, 5'd0, 1'b0, 1'b1),
            item_row(fpr_pkg::OP_WARM,  32'h8000_0000, 5'd0, 1'b1, 1'b1),
            item_row(fpr_pkg::OP_RESID, 32'h7FFF_FFFF, 5'd0, 1'b0, 1'b0),
            reg_row(fpr_pkg::CFG_ORDER, 6'd1),
            item_row(fpr_pkg::OP_RESID, 32'h0000_0001, 5'd0, 1'b0, 1'b0),
            reg_row(fpr_pkg::CFG_ORDER, 6'd2),
            item_row(fpr_pkg::OP_RESID, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b0),
            reg_row(fpr_pkg::CFG_ORDER, 6'd3),
            item_row(fpr_pkg::OP_RESID, 32'h0000_0000, 5'd0, 1'b1, 1'b0),
            reg_row(fpr_pkg::CFG_ORDER, 6'd5),
            item_row(fpr_pkg::OP_RESID, 32'h1234_5678, 5'd0, 1'b0, 1'b1),
            reg_row(fpr_pkg::CFG_ORDER, 6'h3F),
            item_row(fpr_pkg::OP_RESID, 32'hEDCB_A987, 5'h1F, 1'b1, 1'b1),
            reg_row(fpr_pkg::CFG_KIND, 6'h01),
            reg_row(fpr_pkg::CFG_ORDER, 6'd0),
            reg_row(fpr_pkg::CFG_SHIFT, 6'd0),
            item_row(fpr_pkg::OP_RESID, 32'h0000_0055, 5'd0, 1'b0, 1'b1),
            item_row(fpr_pkg::OP_LOAD,  32'h7FFF_C000, 5'd0, 1'b0, 1'b0),
            item_row(fpr_pkg::OP_LOAD,  32'h0000_3FFF, 5'd1, 1'b0, 1'b0),
            item_row(fpr_pkg::OP_LOAD,  32'hFFFF_FFFF, 5'd31, 1'b1, 1'b0),
            reg_row(fpr_pkg::CFG_ORDER, 6'd2),
            reg_row(fpr_pkg::CFG_SHIFT, 6'd15),
            item_row(fpr_pkg::OP_WARM,  32'h8000_0000, 5'd0, 1'b0, 1'b1),
            item_row(fpr_pkg::OP_WARM,  32'h7FFF_FFFF, 5'd0, 1'b0, 1'b1),
            item_row(fpr_pkg::OP_RESID, 32'h7FFF_FFFF, 5'd0, 1'b0, 1'b0),
            reg_row(fpr_pkg::CFG_SHIFT, 6'd0),
            item_row(fpr_pkg::OP_RESID, 32'h8000_0000, 5'd0, 1'b1, 1'b0),
            reg_row(fpr_pkg::CFG_KIND, 6'h3E),
            item_row(fpr_pkg::OP_RESID, 32'h0000_0000, 5'd0, 1'b0, 1'b0)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_ROWS; n++) begin
            if (dir_table[n].kind == ROW_REG)
                reg_write(dir_table[n].reg_idx, dir_table[n].reg_data);
            else
                drive_item(dir_table[n].item, dir_table[n].fixed_want, dir_table[n].want);
        end

        while (items_taken < ITEM_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            use_lpc = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            if (use_lpc)
                ord = (r == 0) ? 6'($urandom_range(33, 63)) :
                      (r == 1) ? 6'd32 : 6'($urandom_range(1, 12));
            else
                ord = (r == 0) ? 6'($urandom_range(5, 63)) : 6'($urandom_range(0, 4));
            r = $urandom_range(0, 5);
            shf = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom_range(0, 15));
            reg_write(fpr_pkg::CFG_KIND, {5'($urandom), use_lpc});
            reg_write(fpr_pkg::CFG_ORDER, ord);
            reg_write(fpr_pkg::CFG_SHIFT, {2'($urandom), shf});

            if (use_lpc) begin
                taps = (ord > fpr_pkg::MAX_ORDER) ? fpr_pkg::MAX_ORDER : int'(ord);
                for (int j = 0; j < taps; j++)
                    send(fpr_pkg::OP_LOAD, $urandom, 5'(j), 1'($urandom));
            end else begin
                taps = (ord <= 4) ? int'(ord) : $urandom_range(0, 4);
            end

            nsub = $urandom_range(1, 3);
            for (int k = 0; k < nsub; k++) begin
                nwarm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, taps) : taps;
                nres = use_lpc ? $urandom_range(2, 10) : $urandom_range(3, 20);
                for (int j = 0; j < nwarm; j++) begin
                    maybe_noise();
                    send(fpr_pkg::OP_WARM, sample_value(), 5'($urandom), 1'b0);
                end
                for (int j = 0; j < nres; j++) begin
                    maybe_noise();
                    send(fpr_pkg::OP_RESID, sample_value(), 5'($urandom), (j == nres - 1));
                end
            end
        end

        smp_in.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/fpr_pkg.sv
hdl/fpr_in_if.sv
hdl/fpr_out_if.sv
hdl/fpr_cell.sv
hdl/fpr_mac.sv
hdl/flac_predictor_restore_core.sv
hdl/fpr_checker.sv
bench/tb_flac_predictor_restore_core.sv
